// File: src/prmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the push-relabel maximum-flow block.
package prmf_pkg;

    localparam int DEF_MAX_NODES = 16;

    localparam int CFG_W    = 5;
    localparam int FIELD_NODE_W = 4;
    localparam int AMT_W    = 31;
    localparam int CAP_W    = 36;
    localparam int FLOW_W   = 37;
    localparam int VAL_W    = 40;
    localparam int IN_DATA_W = 40;
    localparam int IN_USER_W = 2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic {
        KIND_TOTAL = 1'b0,
        KIND_ARC   = 1'b1
    } kind_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_READ_RD,
        ST_READ_DATA,
        ST_SRC_INIT,
        ST_SRC_RD,
        ST_SRC_WR1,
        ST_SRC_WR2,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIS_RD,
        ST_DIS_LD,
        ST_DIS_LOOP,
        ST_PUSH_RD,
        ST_PUSH_EV,
        ST_PUSH_WR2,
        ST_RLB_RD,
        ST_RLB_EV,
        ST_DIS_WB,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_OUT
    } state_t;

endpackage

// File: src/push_relabel_max_flow.sv
`timescale 1ns / 1ps
// Top level of the push-relabel maximum-flow engine on a dense capacity matrix.
//
// Requests arrive on the s_ channel. s_tuser carries the operation: clear the
// matrix, add capacity to one arc, run a maximum-flow computation from node 0
// to node node_count-1, or read the net flow of one arc. s_tdata carries the
// arc's tail and head nodes and the capacity amount. Runs and reads each give
// one result on the m_ channel (m_tuser says which kind, m_tdata holds the
// 40-bit two's complement value); clears and adds give none.
// All state lives in synchronous memories with registered read data and
// is worked through by a single read-modify-write sequencer, one request at a
// time. An add reads the capacity entry and writes it back; a read reads the
// flow entry, loads it as the result and hands it out; a clear sweeps every
// matrix entry. A run first sweeps the flow and node memories, saturates the
// source arcs, then sweeps the inner nodes until none overflows; each arc visit
// reads and then evaluates, and a push that moves flow also writes the reverse
// flow. After reset the block clears all memories in one pass before it takes
// its first request; node_count resets to 2 and may be written at any time the
// block is idle.
// A finished result waits in the output register; the block keeps taking
// clears and adds while the receiver stalls, and holds at the next result
// until the register is free.
module push_relabel_max_flow #(
    parameter int MAX_NODES = prmf_pkg::DEF_MAX_NODES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // from_node [3:0], to_node [7:4], capacity_amount [38:8], zero [39]
    input  logic [prmf_pkg::IN_DATA_W-1:0] s_tdata,
    // operation [1:0]
    input  logic [prmf_pkg::IN_USER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // value [39:0]
    output logic [prmf_pkg::VAL_W-1:0]     m_tdata,
    // result_kind [0]
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [prmf_pkg::CFG_W-1:0]     cfg_wr_data
);

    import prmf_pkg::*;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCNT_W = NODE_W + 1;
    localparam int MAT_D  = MAX_NODES * MAX_NODES;
    localparam int AW     = $clog2(MAT_D);
    localparam int CLR_W  = AW + 1;
    localparam int HGT_W  = $clog2(2 * MAX_NODES + 1);
    // Excess of a node can reach the sum of all its incoming capacities.
    localparam int EXC_W  = CAP_W + NODE_W + 1;

    // Memories
    logic [CAP_W-1:0]  cap_mem  [MAT_D];
    logic [FLOW_W-1:0] flow_mem [MAT_D];
    logic [HGT_W-1:0]  hgt_mem  [MAX_NODES];
    logic [EXC_W-1:0]  exc_mem  [MAX_NODES];
    logic [NCNT_W-1:0] cur_mem  [MAX_NODES];

    logic              cap_we, flow_we, hgt_we, exc_we, cur_we;
    logic [AW-1:0]     cap_wa, cap_ra, flow_wa, flow_ra;
    logic [NODE_W-1:0] hgt_wa, hgt_ra, exc_wa, exc_ra, cur_wa, cur_ra;
    logic [CAP_W-1:0]  cap_wd, cap_rd;
    logic [FLOW_W-1:0] flow_wd, flow_rd;
    logic [HGT_W-1:0]  hgt_wd, hgt_rd;
    logic [EXC_W-1:0]  exc_wd, exc_rd;
    logic [NCNT_W-1:0] cur_wd, cur_rd;

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[cap_wa] <= cap_wd;
        end
        cap_rd <= cap_mem[cap_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_wa] <= flow_wd;
        end
        flow_rd <= flow_mem[flow_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hgt_we)
        begin
            hgt_mem[hgt_wa] <= hgt_wd;
        end
        hgt_rd <= hgt_mem[hgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (exc_we)
        begin
            exc_mem[exc_wa] <= exc_wd;
        end
        exc_rd <= exc_mem[exc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_wa] <= cur_wd;
        end
        cur_rd <= cur_mem[cur_ra];
    end

    function automatic logic [AW-1:0] mat_addr(input logic [NODE_W-1:0] u,
                                               input logic [NODE_W-1:0] v);
        mat_addr = AW'(int'(u) * MAX_NODES + int'(v));
    endfunction

    // Registers
    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                clr_cap_reg, clr_cap_next;
    op_t                 op_reg, op_next;
    logic [NODE_W-1:0]   from_reg, from_next, to_reg, to_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [NCNT_W-1:0]   v_reg, v_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [HGT_W-1:0]    hu_reg, hu_next;
    logic [HGT_W:0]      hmin_reg, hmin_next;
    logic [NCNT_W-1:0]   curu_reg, curu_next;
    logic signed [EXC_W-1:0] excu_reg, excu_next;
    logic                changed_reg, changed_next;
    logic [VAL_W-1:0]    total_reg, total_next;
    logic [FLOW_W-1:0]   fnew_reg, fnew_next;
    kind_t               rkind_reg, rkind_next;
    logic [VAL_W-1:0]    rval_reg, rval_next;
    logic                mvalid_reg, mvalid_next;
    kind_t               mkind_reg, mkind_next;
    logic [VAL_W-1:0]    mval_reg, mval_next;
    logic [CFG_W-1:0]    cfg_reg, cfg_next;

    // Derived values
    logic [NCNT_W-1:0]       n_eff;
    logic                    in_ok;
    logic [NODE_W-1:0]       in_from, in_to;
    logic [NODE_W-1:0]       v_idx;
    logic [HGT_W-1:0]        hv;
    logic signed [EXC_W-1:0] cap_ext, flow_ext, resid, push_amt, exc_v;
    logic [CAP_W:0]          cap_sum;
    logic [FLOW_W-1:0]       flow_plus;

    always_comb
    begin
        if (cfg_reg < CFG_W'(2))
        begin
            n_eff = NCNT_W'(2);
        end
        else if (int'(cfg_reg) > MAX_NODES)
        begin
            n_eff = NCNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = NCNT_W'(cfg_reg);
        end
    end

    assign in_from = NODE_W'(s_tdata[3:0]);
    assign in_to   = NODE_W'(s_tdata[7:4]);
    assign in_ok   = (int'(s_tdata[3:0]) < MAX_NODES) && (int'(s_tdata[7:4]) < MAX_NODES);
    assign v_idx   = v_reg[NODE_W-1:0];
    // The node under discharge keeps its height in a register only.
    assign hv       = (v_idx == u_reg) ? hu_reg : hgt_rd;
    assign cap_ext  = $signed({{(EXC_W-CAP_W){1'b0}}, cap_rd});
    assign flow_ext = $signed({{(EXC_W-FLOW_W){flow_rd[FLOW_W-1]}}, flow_rd});
    assign resid    = cap_ext - flow_ext;
    assign push_amt = (excu_reg < resid) ? excu_reg : resid;
    assign exc_v    = $signed(exc_rd);
    assign cap_sum  = {1'b0, cap_rd} + (CAP_W+1)'(amt_reg);
    assign flow_plus = FLOW_W'(flow_ext + push_amt);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mval_reg;
    assign m_tuser  = mkind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_idx_reg <= '0;
            clr_cap_reg <= 1'b1;
            op_reg      <= OP_CLEAR;
            from_reg    <= '0;
            to_reg      <= '0;
            amt_reg     <= '0;
            v_reg       <= '0;
            u_reg       <= '0;
            hu_reg      <= '0;
            hmin_reg    <= '0;
            curu_reg    <= '0;
            excu_reg    <= '0;
            changed_reg <= 1'b0;
            total_reg   <= '0;
            fnew_reg    <= '0;
            rkind_reg   <= KIND_TOTAL;
            rval_reg    <= '0;
            mvalid_reg  <= 1'b0;
            mkind_reg   <= KIND_TOTAL;
            mval_reg    <= '0;
            cfg_reg     <= CFG_W'(2);
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            clr_cap_reg <= clr_cap_next;
            op_reg      <= op_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            amt_reg     <= amt_next;
            v_reg       <= v_next;
            u_reg       <= u_next;
            hu_reg      <= hu_next;
            hmin_reg    <= hmin_next;
            curu_reg    <= curu_next;
            excu_reg    <= excu_next;
            changed_reg <= changed_next;
            total_reg   <= total_next;
            fnew_reg    <= fnew_next;
            rkind_reg   <= rkind_next;
            rval_reg    <= rval_next;
            mvalid_reg  <= mvalid_next;
            mkind_reg   <= mkind_next;
            mval_reg    <= mval_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        clr_cap_next = clr_cap_reg;
        op_next      = op_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        amt_next     = amt_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        hu_next      = hu_reg;
        hmin_next    = hmin_reg;
        curu_next    = curu_reg;
        excu_next    = excu_reg;
        changed_next = changed_reg;
        total_next   = total_reg;
        fnew_next    = fnew_reg;
        rkind_next   = rkind_reg;
        rval_next    = rval_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mkind_next   = mkind_reg;
        mval_next    = mval_reg;
        cfg_next     = cfg_wr_en ? cfg_wr_data : cfg_reg;

        cap_we  = 1'b0;  cap_wa  = '0;  cap_wd  = '0;  cap_ra  = '0;
        flow_we = 1'b0;  flow_wa = '0;  flow_wd = '0;  flow_ra = '0;
        hgt_we  = 1'b0;  hgt_wa  = '0;  hgt_wd  = '0;  hgt_ra  = '0;
        exc_we  = 1'b0;  exc_wa  = '0;  exc_wd  = '0;  exc_ra  = '0;
        cur_we  = 1'b0;  cur_wa  = '0;  cur_wd  = '0;  cur_ra  = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                // One matrix entry, and one node entry while in range, per cycle.
                cap_we  = clr_cap_reg;
                cap_wa  = clr_idx_reg[AW-1:0];
                flow_we = 1'b1;
                flow_wa = clr_idx_reg[AW-1:0];
                if (int'(clr_idx_reg) < MAX_NODES)
                begin
                    hgt_we = 1'b1;
                    hgt_wa = clr_idx_reg[NODE_W-1:0];
                    exc_we = 1'b1;
                    exc_wa = clr_idx_reg[NODE_W-1:0];
                    cur_we = 1'b1;
                    cur_wa = clr_idx_reg[NODE_W-1:0];
                end
                if (int'(clr_idx_reg) == MAT_D - 1)
                begin
                    clr_idx_next = '0;
                    state_next   = (op_reg == OP_RUN) ? ST_SRC_INIT : ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + CLR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next   = op_t'(s_tuser);
                    from_next = in_from;
                    to_next   = in_to;
                    amt_next  = s_tdata[38:8];
                    unique case (op_t'(s_tuser))
                        OP_CLEAR:
                        begin
                            clr_cap_next = 1'b1;
                            clr_idx_next = '0;
                            state_next   = ST_CLR;
                        end
                        OP_ADD:
                        begin
                            state_next = in_ok ? ST_ADD_RD : ST_IDLE;
                        end
                        OP_RUN:
                        begin
                            clr_cap_next = 1'b0;
                            clr_idx_next = '0;
                            state_next   = ST_CLR;
                        end
                        OP_READ:
                        begin
                            rkind_next = KIND_ARC;
                            rval_next  = '0;
                            state_next = in_ok ? ST_READ_RD : ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD_RD:
            begin
                cap_ra     = mat_addr(from_reg, to_reg);
                state_next = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                // Saturate at the largest capacity.
                cap_we     = 1'b1;
                cap_wa     = mat_addr(from_reg, to_reg);
                cap_wd     = cap_sum[CAP_W] ? '1 : cap_sum[CAP_W-1:0];
                state_next = ST_IDLE;
            end

            ST_READ_RD:
            begin
                flow_ra    = mat_addr(from_reg, to_reg);
                state_next = ST_READ_DATA;
            end

            ST_READ_DATA:
            begin
                rval_next  = VAL_W'(flow_ext);
                state_next = ST_OUT;
            end

            ST_SRC_INIT:
            begin
                hgt_we     = 1'b1;
                hgt_wa     = '0;
                hgt_wd     = HGT_W'(n_eff);
                v_next     = NCNT_W'(1);
                state_next = ST_SRC_RD;
            end

            ST_SRC_RD:
            begin
                cap_ra     = mat_addr('0, v_idx);
                state_next = ST_SRC_WR1;
            end

            ST_SRC_WR1:
            begin
                // Flows are zero after the sweep, so the push is the whole capacity.
                flow_we    = 1'b1;
                flow_wa    = mat_addr('0, v_idx);
                flow_wd    = FLOW_W'(cap_ext);
                exc_we     = 1'b1;
                exc_wa     = v_idx;
                exc_wd     = cap_ext;
                fnew_next  = FLOW_W'(cap_ext);
                state_next = ST_SRC_WR2;
            end

            ST_SRC_WR2:
            begin
                flow_we = 1'b1;
                flow_wa = mat_addr(v_idx, '0);
                flow_wd = FLOW_W'(-$signed(fnew_reg));
                if (v_reg + NCNT_W'(1) == n_eff)
                begin
                    v_next       = NCNT_W'(1);
                    changed_next = 1'b0;
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    v_next     = v_reg + NCNT_W'(1);
                    state_next = ST_SRC_RD;
                end
            end

            ST_SCAN_RD:
            begin
                if (v_reg + NCNT_W'(1) >= n_eff)
                begin
                    // End of a sweep over the inner nodes.
                    if (changed_reg)
                    begin
                        changed_next = 1'b0;
                        v_next       = NCNT_W'(1);
                    end
                    else
                    begin
                        v_next     = NCNT_W'(1);
                        total_next = '0;
                        state_next = ST_SUM_RD;
                    end
                end
                else
                begin
                    exc_ra     = v_idx;
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (exc_v > 0)
                begin
                    changed_next = 1'b1;
                    u_next       = v_idx;
                    excu_next    = exc_v;
                    state_next   = ST_DIS_RD;
                end
                else
                begin
                    v_next     = v_reg + NCNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_DIS_RD:
            begin
                hgt_ra     = u_reg;
                cur_ra     = u_reg;
                state_next = ST_DIS_LD;
            end

            ST_DIS_LD:
            begin
                hu_next    = hgt_rd;
                curu_next  = cur_rd;
                state_next = ST_DIS_LOOP;
            end

            ST_DIS_LOOP:
            begin
                if (excu_reg <= 0)
                begin
                    state_next = ST_DIS_WB;
                end
                else if (curu_reg >= n_eff)
                begin
                    v_next     = '0;
                    hmin_next  = (HGT_W+1)'({n_eff, 1'b0});
                    state_next = ST_RLB_RD;
                end
                else
                begin
                    v_next     = curu_reg;
                    state_next = ST_PUSH_RD;
                end
            end

            ST_PUSH_RD:
            begin
                hgt_ra     = v_idx;
                exc_ra     = v_idx;
                cap_ra     = mat_addr(u_reg, v_idx);
                flow_ra    = mat_addr(u_reg, v_idx);
                state_next = ST_PUSH_EV;
            end

            ST_PUSH_EV:
            begin
                if (({1'b0, hu_reg} == {1'b0, hv} + (HGT_W+1)'(1)) && (push_amt != 0))
                begin
                    flow_we    = 1'b1;
                    flow_wa    = mat_addr(u_reg, v_idx);
                    flow_wd    = flow_plus;
                    exc_we     = 1'b1;
                    exc_wa     = v_idx;
                    exc_wd     = exc_v + push_amt;
                    excu_next  = excu_reg - push_amt;
                    fnew_next  = flow_plus;
                    state_next = ST_PUSH_WR2;
                end
                else
                begin
                    curu_next  = curu_reg + NCNT_W'(1);
                    state_next = ST_DIS_LOOP;
                end
            end

            ST_PUSH_WR2:
            begin
                // Net flow stays antisymmetric.
                flow_we    = 1'b1;
                flow_wa    = mat_addr(v_idx, u_reg);
                flow_wd    = FLOW_W'(-$signed(fnew_reg));
                curu_next  = curu_reg + NCNT_W'(1);
                state_next = ST_DIS_LOOP;
            end

            ST_RLB_RD:
            begin
                hgt_ra     = v_idx;
                cap_ra     = mat_addr(u_reg, v_idx);
                flow_ra    = mat_addr(u_reg, v_idx);
                state_next = ST_RLB_EV;
            end

            ST_RLB_EV:
            begin
                if ((resid != 0) && ({1'b0, hv} + (HGT_W+1)'(1) < hmin_reg))
                begin
                    hmin_next = {1'b0, hv} + (HGT_W+1)'(1);
                end
                if (v_reg + NCNT_W'(1) == n_eff)
                begin
                    if ((resid != 0) && ({1'b0, hv} + (HGT_W+1)'(1) < hmin_reg))
                    begin
                        hu_next = HGT_W'({1'b0, hv} + (HGT_W+1)'(1));
                    end
                    else
                    begin
                        hu_next = hmin_reg[HGT_W-1:0];
                    end
                    curu_next  = '0;
                    state_next = ST_DIS_LOOP;
                end
                else
                begin
                    v_next     = v_reg + NCNT_W'(1);
                    state_next = ST_RLB_RD;
                end
            end

            ST_DIS_WB:
            begin
                hgt_we     = 1'b1;
                hgt_wa     = u_reg;
                hgt_wd     = hu_reg;
                cur_we     = 1'b1;
                cur_wa     = u_reg;
                cur_wd     = curu_reg;
                exc_we     = 1'b1;
                exc_wa     = u_reg;
                exc_wd     = excu_reg;
                v_next     = NCNT_W'(u_reg) + NCNT_W'(1);
                state_next = ST_SCAN_RD;
            end

            ST_SUM_RD:
            begin
                flow_ra    = mat_addr('0, v_idx);
                state_next = ST_SUM_ACC;
            end

            ST_SUM_ACC:
            begin
                total_next = total_reg + VAL_W'(flow_ext);
                if (v_reg + NCNT_W'(1) == n_eff)
                begin
                    rkind_next = KIND_TOTAL;
                    rval_next  = total_reg + VAL_W'(flow_ext);
                    state_next = ST_OUT;
                end
                else
                begin
                    v_next     = v_reg + NCNT_W'(1);
                    state_next = ST_SUM_RD;
                end
            end

            ST_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = rkind_reg;
                    mval_next   = rval_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the push-relabel maximum-flow block, with randomised stream traffic.
module tb_top;
    import prmf_pkg::*;

    localparam int NN = DEF_MAX_NODES;
    localparam longint CAP_SAT = 64'hF_FFFF_FFFF;
    localparam int QUIET_LIMIT = 400000;
    localparam int SETTLE = 300;

    typedef struct {
        op_t         op;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [30:0] amount;
    } request_t;

    typedef struct {
        kind_t       kind;
        logic [39:0] value;
    } flow_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [VAL_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    // Bench-side copy of the block's state.
    longint arc_cap [NN*NN];
    longint arc_net [NN*NN];
    int     height [NN];
    longint excess [NN];
    int     cursor [NN];
    logic [4:0] nodes_reg;

    request_t     pending_requests [$];
    flow_result_t expected_flows [$];
    int src_idle_pct;
    int snk_idle_pct;
    int failures;
    int n_requests;
    int n_results;
    int n_runs;
    int quiet_cycles;
    bit took;

    push_relabel_max_flow DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int used_nodes();
        if (nodes_reg < 2) return 2;
        if (nodes_reg > NN) return NN;
        return int'(nodes_reg);
    endfunction

    function automatic void zero_flows();
        foreach (arc_net[i]) arc_net[i] = 0;
        foreach (height[i])
        begin
            height[i] = 0;
            excess[i] = 0;
            cursor[i] = 0;
        end
    endfunction

    function automatic void move_flow(int u, int v, longint d);
        arc_net[u*NN+v] += d;
        arc_net[v*NN+u] -= d;
        excess[v] += d;
        excess[u] -= d;
    endfunction

    // Push-relabel with index-order sweeps; returns the flow leaving the source.
    function automatic longint max_flow();
        int n;
        int sink;
        int v;
        int h;
        bit busy;
        longint r;
        longint total;
        n = used_nodes();
        sink = n - 1;
        total = 0;
        zero_flows();
        height[0] = n;
        for (int w = 0; w < n; w++) move_flow(0, w, arc_cap[w] - arc_net[w]);
        busy = 1'b1;
        while (busy)
        begin
            busy = 1'b0;
            for (int u = 1; u < sink; u++)
            begin
                if (excess[u] > 0)
                begin
                    busy = 1'b1;
                    while (excess[u] > 0)
                    begin
                        v = cursor[u];
                        if (v >= n)
                        begin
                            // Relabel to one above the lowest unsaturated neighbour.
                            h = 2 * n;
                            for (int w = 0; w < n; w++)
                                if (arc_cap[u*NN+w] - arc_net[u*NN+w] != 0 && height[w] + 1 < h)
                                    h = height[w] + 1;
                            height[u] = h;
                            cursor[u] = 0;
                        end
                        else
                        begin
                            if (height[u] == height[v] + 1)
                            begin
                                r = arc_cap[u*NN+v] - arc_net[u*NN+v];
                                move_flow(u, v, (excess[u] < r) ? excess[u] : r);
                            end
                            cursor[u] = v + 1;
                        end
                    end
                end
            end
        end
        for (int w = 1; w < n; w++) total += arc_net[w];
        return total;
    endfunction

    function automatic void predict(request_t rq);
        flow_result_t res;
        longint c;
        case (rq.op)
            OP_CLEAR:
            begin
                foreach (arc_cap[i]) arc_cap[i] = 0;
                zero_flows();
            end
            OP_ADD:
            begin
                c = arc_cap[rq.src*NN+rq.dst];
                arc_cap[rq.src*NN+rq.dst] =
                    (CAP_SAT - c < longint'(rq.amount)) ? CAP_SAT : c + rq.amount;
            end
            OP_RUN:
            begin
                res.kind = KIND_TOTAL;
                res.value = 40'(max_flow());
                expected_flows.insert(expected_flows.size(), res);
                n_runs++;
            end
            default:
            begin
                res.kind = KIND_ARC;
                res.value = 40'(arc_net[rq.src*NN+rq.dst]);
                expected_flows.insert(expected_flows.size(), res);
            end
        endcase
    endfunction

    // Acceptance on both channels is seen at the rising edge.
    always @(posedge clk)
    begin
        took = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            took = 1'b1;
            predict(pending_requests.pop_front());
            n_requests++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_flows.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d", m_tuser, $signed(m_tdata));
                failures++;
            end
            else
            begin
                if (m_tuser[0] !== expected_flows[0].kind)
                begin
                    $error("result_kind: expected %0d, got %0d", expected_flows[0].kind, m_tuser);
                    failures++;
                end
                if (m_tdata !== expected_flows[0].value)
                begin
                    $error("value: expected %0d, got %0d",
                           $signed(expected_flows[0].value), $signed(m_tdata));
                    failures++;
                end
                void'(expected_flows.pop_front());
            end
        end
    end

    // Driver: a request that is up stays up until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
            if (s_tvalid && !took)
                s_tvalid <= 1'b1;
            else if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_requests[0].op;
                s_tdata <= {1'b0, pending_requests[0].amount, pending_requests[0].dst,
                            pending_requests[0].src};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Watchdog on cycles with no traffic on either channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_flows.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(op_t op, int f, int t, int unsigned amt);
        request_t rq;
        rq.op = op;
        rq.src = f[3:0];
        rq.dst = t[3:0];
        rq.amount = amt[30:0];
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    // Wait for the block to drain, then wait long enough for a clear to finish.
    task automatic settle();
        while (pending_requests.size() > 0 || expected_flows.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_nodes(logic [4:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        nodes_reg = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned rand_amount();
        case ($urandom_range(3))
            0: return $urandom_range(20);
            1: return $urandom_range(1000);
            2: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // A well-formed graph job with random content, sometimes with noise mixed in.
    task automatic random_job(int n);
        int adds;
        if ($urandom_range(3) != 0) send(OP_CLEAR, $urandom_range(15), $urandom_range(15), $urandom());
        adds = $urandom_range(3, 9);
        repeat (adds)
        begin
            if ($urandom_range(9) == 0)
                send(OP_ADD, $urandom_range(15), $urandom_range(15), rand_amount());
            else
                send(OP_ADD, $urandom_range(n-1), $urandom_range(n-1), rand_amount());
        end
        if ($urandom_range(9) == 0)
            send(op_t'($urandom_range(3)), $urandom_range(15), $urandom_range(15), $urandom());
        send(OP_RUN, $urandom_range(15), $urandom_range(15), $urandom());
        repeat ($urandom_range(1, 3)) send(OP_READ, $urandom_range(15), $urandom_range(15), 0);
    endtask

    initial
    begin
        int pct_src [4] = '{0, 66, 0, 29};
        int pct_snk [4] = '{0, 0, 66, 29};
        logic [4:0] cfg_plan [8] = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd16, 5'd9, 5'd1};
        int n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        nodes_reg = 5'd2;
        failures = 0;
        n_requests = 0;
        n_results = 0;
        n_runs = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        foreach (arc_cap[i]) arc_cap[i] = 0;
        zero_flows();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        // The block clears its memories after reset before it is idle.
        repeat (SETTLE) @(posedge clk);

        // Directed: full-size graph with extreme amounts, a self loop and reverse reads.
        set_nodes(5'd16);
        send(OP_CLEAR, 15, 15, 32'h7FFF_FFFF);
        send(OP_ADD, 0, 5, 32'h7FFF_FFFF);
        send(OP_ADD, 5, 15, 32'h7FFF_FFFF);
        send(OP_ADD, 0, 7, 0);
        send(OP_ADD, 5, 5, 100);
        send(OP_ADD, 0, 10, 7);
        send(OP_ADD, 10, 5, 3);
        send(OP_ADD, 10, 15, 2);
        send(OP_RUN, 0, 0, 0);
        send(OP_READ, 0, 5, 0);
        send(OP_READ, 5, 0, 0);
        send(OP_READ, 5, 5, 0);
        send(OP_READ, 10, 15, 0);
        send(OP_RUN, 15, 15, 0);
        send(OP_READ, 15, 10, 0);
        settle();

        // Fewer nodes in use: arcs on the unused ones must carry nothing.
        set_nodes(5'd3);
        send(OP_ADD, 0, 7, 9);
        send(OP_ADD, 7, 2, 9);
        send(OP_ADD, 0, 1, 4);
        send(OP_ADD, 1, 2, 6);
        send(OP_RUN, 0, 0, 0);
        send(OP_READ, 0, 7, 0);
        send(OP_READ, 1, 2, 0);
        settle();

        // Saturation: repeated largest adds onto a single source-to-sink arc.
        set_nodes(5'd0);
        send(OP_CLEAR, 0, 0, 0);
        repeat (34) send(OP_ADD, 0, 1, 32'h7FFF_FFFF);
        send(OP_RUN, 0, 0, 0);
        send(OP_READ, 1, 0, 0);
        settle();

        // Random phases over node counts and all idling patterns.
        for (int p = 0; p < 8; p++)
        begin
            set_nodes(cfg_plan[p]);
            n = used_nodes();
            src_idle_pct = pct_src[p % 4];
            snk_idle_pct = pct_snk[p % 4];
            random_job(n);
            settle();
        end
        src_idle_pct = 0;
        snk_idle_pct = 0;

        $display("Ran %0d requests including %0d max-flow runs; %0d results checked.",
                 n_requests, n_runs, n_results);
        $display("Node counts from below range to above range, with both sides stalling.");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/prmf_pkg.sv
src/push_relabel_max_flow.sv
bench/tb_top.sv
